[hw/rtl/dnsle_pkg.sv]
// Shared constants and types for the DNS name label encoder.
// Used by dnsle_ctrl, dnsle_datapath, dns_name_label_encoder and the testbench; no dependencies.
package dnsle_pkg;

  localparam int LABEL_MAX_DEF = 62;
  localparam int CHAR_W        = 8;
  localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

  // Source of the byte loaded into the output register
  typedef enum logic [1:0] {
    SEL_LEN  = 2'd0,
    SEL_DATA = 2'd1,
    SEL_TERM = 2'd2
  } out_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     store_char;  // buffer the incoming character or flag overflow
    logic     issue_read;  // read the label store at the replay index
    logic     out_load;    // load the output register
    out_sel_t out_sel;
    logic     out_last;
    logic     clear_label; // drop count and overflow flag
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_dot;
    logic in_end;
    logic count_zero;
    logic idx_last;
    logic out_free;
  } dp_sts_t;

endpackage

[hw/rtl/dnsle_datapath.sv]
// Datapath of the DNS name label encoder: label store, count, replay index
// and output register. Depends on dnsle_pkg; driven by dnsle_ctrl.
module dnsle_datapath #(
  parameter int LABEL_MAX = dnsle_pkg::LABEL_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dnsle_pkg::dp_cmd_t cmd,
  output dnsle_pkg::dp_sts_t sts,
  input  logic [7:0]         s_tdata,  // [7:0] name_char
  input  logic               s_tuser,  // [0] end_of_name
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic [7:0]         m_tdata,  // [7:0] out_byte
  output logic               m_tlast,  // run_last
  output logic               m_tuser   // [0] label_overflow
);
  import dnsle_pkg::*;

  localparam int CNT_W  = $clog2(LABEL_MAX + 1);
  localparam int ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  logic [CHAR_W-1:0] mem [LABEL_MAX];
  logic [CHAR_W-1:0] rd_data;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic              ovf;
  logic              room;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_last;
  logic              out_ovf;

  assign room = (count < CNT_W'(LABEL_MAX));

  always_comb begin
    sts.in_dot     = (s_tdata == DOT_CHAR);
    sts.in_end     = s_tuser;
    sts.count_zero = (count == '0);
    sts.idx_last   = (CNT_W'(idx + 1'b1) == count);
    sts.out_free   = !out_valid || m_tready;
  end

  // Label store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store_char && room) begin
      mem[count[ADDR_W-1:0]] <= s_tdata;
    end
    if (cmd.issue_read) begin
      rd_data <= mem[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.clear_label) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.store_char) begin
      if (room) begin
        count <= CNT_W'(count + 1'b1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Replay index: restart on the length byte, advance per character sent
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.out_load && cmd.out_sel == SEL_LEN) begin
      idx <= '0;
    end else if (cmd.out_load && cmd.out_sel == SEL_DATA) begin
      idx <= CNT_W'(idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last <= cmd.out_last;
      unique case (cmd.out_sel)
        SEL_LEN: begin
          out_byte <= 8'(count);
          out_ovf  <= ovf;
        end
        SEL_DATA: begin
          out_byte <= rd_data;
          out_ovf  <= ovf;
        end
        default: begin
          out_byte <= 8'h00;
          out_ovf  <= 1'b0;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;
  assign m_tuser  = out_ovf;

endmodule

[hw/rtl/dnsle_ctrl.sv]
// Controller of the DNS name label encoder: accepts items and sequences the
// length byte, label replay and terminator. Depends on dnsle_pkg.
module dnsle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output dnsle_pkg::dp_cmd_t cmd,
  input  dnsle_pkg::dp_sts_t sts
);
  import dnsle_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DATA = 3'd3;
  localparam logic [2:0] S_TERM = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       is_end;
  logic       is_end_next;
  logic       accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next  = state;
    is_end_next = is_end;
    cmd         = '0;
    cmd.out_sel = SEL_LEN;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.in_end || sts.in_dot) begin
            is_end_next = sts.in_end;
            state_next  = S_LEN;
          end else begin
            cmd.store_char = 1'b1;
          end
        end
      end
      S_LEN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_LEN;
          cmd.out_last = !is_end && sts.count_zero;
          if (sts.count_zero) begin
            cmd.clear_label = 1'b1;
            state_next      = is_end ? S_TERM : S_IDLE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.issue_read = 1'b1;
        state_next     = S_DATA;
      end
      S_DATA: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_DATA;
          cmd.out_last = !is_end && sts.idx_last;
          if (sts.idx_last) begin
            cmd.clear_label = 1'b1;
            state_next      = is_end ? S_TERM : S_IDLE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_TERM: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_TERM;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      is_end <= 1'b0;
    end else begin
      state  <= state_next;
      is_end <= is_end_next;
    end
  end

endmodule

[hw/rtl/dns_name_label_encoder.sv]
// Top level of the DNS name label encoder: controller plus datapath.
// Depends on dnsle_pkg, dnsle_ctrl and dnsle_datapath.
//
// Turns a dotted host name into DNS wire-format labels. Send one character
// per transfer on the slave side with tuser low, then one transfer with tuser
// high to end the name (its tdata is ignored). Ordinary characters are
// buffered and produce nothing; a dot emits the label's length byte followed
// by its characters; the end transfer does the same for the final label and
// then emits a zero byte. tlast marks the final byte caused by one input
// transfer. Empty labels (leading, doubled or trailing dots) give a zero
// length byte. Characters beyond LABEL_MAX in one label are dropped, the
// length byte reports LABEL_MAX, and tuser is high on every byte of that
// label. Timing: character transfers are taken back to back; a dot or end
// transfer holds the input while the length byte, each buffered character and
// (for an end transfer) the terminator are emitted, because each character is
// replayed through the label store's registered read port, with a read step
// and an output load step each. A low tready on a waiting output byte stalls
// the sequence further. The output register lets the last byte wait on tready
// while the next character is taken. No clearing pass after reset.
module dns_name_label_encoder #(
  parameter int LABEL_MAX = dnsle_pkg::LABEL_MAX_DEF  // 1..62
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] name_char
  input  logic       s_tuser,   // [0] end_of_name
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // [0] label_overflow
);
  import dnsle_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence acceptance, replay and terminator
  dnsle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Hold the label and drive the output register
  dnsle_datapath #(
    .LABEL_MAX (LABEL_MAX)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for dns_name_label_encoder: directed table, then random host names.
// Depends on dnsle_pkg and the dns_name_label_encoder RTL; reads no files.
module testbench;

  localparam int LABEL_MAX   = dnsle_pkg::LABEL_MAX_DEF;
  localparam int ITEM_TARGET = 370;
  localparam int DIR_ROWS    = 22;

  // One encoded byte as it leaves the master side
  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
    logic       label_overflow;
  } wire_byte_t;

  // Directed row: a character (or end marker) sent reps times; where typed is set,
  // the first byte it causes (the length byte) is checked against exp_len/exp_ovf
  typedef struct packed {
    logic [7:0] ch;
    logic       eon;
    logic [7:0] reps;
    logic       typed;
    logic [7:0] exp_len;
    logic       exp_ovf;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] name_char
  logic       s_tuser = 1'b0;    // [0] end_of_name
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;           // run_last
  logic       m_tuser;           // [0] label_overflow

  // Shadow of the label being built
  logic [7:0] lbl_buf [LABEL_MAX];
  int         lbl_len = 0;
  logic       lbl_ovf = 1'b0;

  wire_byte_t item_bytes [$];    // bytes caused by the item just accepted
  wire_byte_t wire_bytes_q [$];  // encoded bytes still awaited from the block
  wire_byte_t got_exp;

  int err_cnt     = 0;
  int tx_idle_pct = 35;
  int rx_idle_pct = 74;
  int items_sent  = 0;

  dir_row_t dir_tab [DIR_ROWS];

  dns_name_label_encoder #(.LABEL_MAX(LABEL_MAX)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Emit the length byte and the buffered characters, then clear the label
  function automatic void flush_label(input logic last_of_item);
    wire_byte_t b;
    b.out_byte       = 8'(lbl_len);
    b.label_overflow = lbl_ovf;
    b.run_last       = last_of_item && (lbl_len == 0);
    item_bytes.push_back(b);
    for (int i = 0; i < lbl_len; i++) begin
      b.out_byte = lbl_buf[i];
      b.run_last = last_of_item && (i == lbl_len - 1);
      item_bytes.push_back(b);
    end
    lbl_len = 0;
    lbl_ovf = 1'b0;
  endfunction

  // Predict the wire-format bytes caused by one accepted transfer
  function automatic void encode_item(input logic [7:0] ch, input logic eon);
    wire_byte_t term;
    item_bytes.delete();
    if (eon) begin
      flush_label(1'b0);
      term.out_byte       = 8'h00;
      term.run_last       = 1'b1;
      term.label_overflow = 1'b0;
      item_bytes.push_back(term);
    end else if (ch == dnsle_pkg::DOT_CHAR) begin
      flush_label(1'b1);
    end else if (lbl_len < LABEL_MAX) begin
      lbl_buf[lbl_len] = ch;
      lbl_len++;
    end else begin
      // label full: drop the character, flag the whole label
      lbl_ovf = 1'b1;
    end
  endfunction

  // Drive one transfer on the slave side. Enter and leave at a falling edge; insert
  // random gaps first, then hold tvalid until the block takes the transfer. tvalid
  // stays high on leaving; the next call or the caller drops it.
  task automatic send_item(input logic [7:0] ch, input logic eon,
                           input logic typed = 1'b0, input logic [7:0] exp_len = 8'h00,
                           input logic exp_ovf = 1'b0);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= eon;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encode_item(ch, eon);
    // hand-typed length byte overrides the prediction so a predictor slip shows up
    if (typed) begin
      item_bytes[0].out_byte       = exp_len;
      item_bytes[0].label_overflow = exp_ovf;
    end
    foreach (item_bytes[i]) wire_bytes_q.push_back(item_bytes[i]);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every awaited byte is out, then switch idle rates
  task automatic enter_phase(input int tx_pct, input int rx_pct);
    s_tvalid <= 1'b0;
    while (wire_bytes_q.size() != 0) @(posedge clk);
    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Receiver backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Compare every output transfer with the oldest awaited byte
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (wire_bytes_q.size() == 0) begin
        $error("unexpected output transfer: out_byte %0d last %0b ovf %0b",
               m_tdata, m_tlast, m_tuser);
        err_cnt++;
      end else begin
        got_exp = wire_bytes_q.pop_front();
        if (m_tdata !== got_exp.out_byte) begin
          $error("out_byte: expected %0d, got %0d", got_exp.out_byte, m_tdata);
          err_cnt++;
        end
        if (m_tlast !== got_exp.run_last) begin
          $error("run_last: expected %0b, got %0b", got_exp.run_last, m_tlast);
          err_cnt++;
        end
        if (m_tuser !== got_exp.label_overflow) begin
          $error("label_overflow: expected %0b, got %0b", got_exp.label_overflow, m_tuser);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int         rand_start;
    int         rand_len;
    int         n_lbl;
    int         len;
    logic [7:0] ch;

    dir_tab = '{
      '{8'hFF, 1'b1, 8'd1, 1'b1, 8'd0, 1'b0},                // empty name right after reset
      '{dnsle_pkg::DOT_CHAR, 1'b0, 8'd1, 1'b1, 8'd0, 1'b0},  // leading dot
      '{8'h00, 1'b0, 8'd1, 1'b0, 8'd0, 1'b0},
      '{8'hFF, 1'b0, 8'd1, 1'b0, 8'd0, 1'b0},
      '{dnsle_pkg::DOT_CHAR, 1'b0, 8'd1, 1'b1, 8'd2, 1'b0},
      '{dnsle_pkg::DOT_CHAR, 1'b0, 8'd1, 1'b1, 8'd0, 1'b0},  // two dots in a row
      '{8'h2D, 1'b0, 8'd1, 1'b0, 8'd0, 1'b0},                // neighbors of the dot code
      '{8'h2F, 1'b0, 8'd1, 1'b0, 8'd0, 1'b0},
      '{8'h5A, 1'b0, 8'd1, 1'b0, 8'd0, 1'b0},
      '{dnsle_pkg::DOT_CHAR, 1'b1, 8'd1, 1'b1, 8'd3, 1'b0},  // end item ignores its dot
      '{8'h61, 1'b0, 8'(LABEL_MAX), 1'b0, 8'd0, 1'b0},       // label exactly full
      '{dnsle_pkg::DOT_CHAR, 1'b0, 8'd1, 1'b1, 8'(LABEL_MAX), 1'b0},
      '{8'hA5, 1'b0, 8'(LABEL_MAX + 8), 1'b0, 8'd0, 1'b0},   // long label, closed by end
      '{8'h00, 1'b1, 8'd1, 1'b1, 8'(LABEL_MAX), 1'b1},
      '{8'h7E, 1'b0, 8'(LABEL_MAX + 1), 1'b0, 8'd0, 1'b0},   // one past full, closed by dot
      '{dnsle_pkg::DOT_CHAR, 1'b0, 8'd1, 1'b1, 8'(LABEL_MAX), 1'b1},
      '{8'h62, 1'b0, 8'd1, 1'b0, 8'd0, 1'b0},
      '{dnsle_pkg::DOT_CHAR, 1'b0, 8'd1, 1'b1, 8'd1, 1'b0},  // trailing dot
      '{8'h00, 1'b1, 8'd1, 1'b1, 8'd0, 1'b0},
      '{8'h55, 1'b0, 8'd1, 1'b0, 8'd0, 1'b0},
      '{8'hAA, 1'b0, 8'd1, 1'b0, 8'd0, 1'b0},
      '{8'h00, 1'b1, 8'd1, 1'b1, 8'd2, 1'b0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table, sender 35 / receiver 74 percent idle
    foreach (dir_tab[r]) begin
      for (int k = 0; k < dir_tab[r].reps; k++) begin
        send_item(dir_tab[r].ch, dir_tab[r].eon,
                  dir_tab[r].typed, dir_tab[r].exp_len, dir_tab[r].exp_ovf);
      end
    end

    // Random host names fill up the item budget; idle rates swap a third of the
    // way in, then stop
    rand_start = items_sent;
    rand_len   = ITEM_TARGET - items_sent;
    while (items_sent - rand_start < rand_len) begin
      if (tx_idle_pct == 35 && items_sent - rand_start >= rand_len / 3) begin
        enter_phase(74, 35);
      end else if (tx_idle_pct == 74 && items_sent - rand_start >= 2 * rand_len / 3) begin
        enter_phase(0, 0);
      end

      if ($urandom_range(9) == 0) begin
        // noise: any character, dot or end marker
        send_item(8'($urandom_range(255)), ($urandom_range(5) == 0));
      end else begin
        n_lbl = $urandom_range(1, 4);
        for (int l = 0; l < n_lbl; l++) begin
          if ($urandom_range(39) == 0) len = $urandom_range(LABEL_MAX - 2, LABEL_MAX + 5);
          else len = $urandom_range(0, 9);
          for (int c = 0; c < len; c++) begin
            do ch = 8'($urandom_range(255)); while (ch == dnsle_pkg::DOT_CHAR);
            send_item(ch, 1'b0);
          end
          if (l < n_lbl - 1) send_item(dnsle_pkg::DOT_CHAR, 1'b0);
        end
        if ($urandom_range(7) == 0) send_item(dnsle_pkg::DOT_CHAR, 1'b0);
        // occasionally drop the end marker so names run together
        if ($urandom_range(9) != 0) send_item(8'($urandom_range(255)), 1'b1);
      end
    end

    // Flush whatever label is still open so every byte is accounted for
    send_item(8'h00, 1'b1);
    s_tvalid <= 1'b0;

    while (wire_bytes_q.size() != 0) @(posedge clk);
    // Watch for stray bytes beyond the last expected one
    repeat (4 * LABEL_MAX + 16) @(posedge clk);

    if (err_cnt == 0) begin
      $display("dns_name_label_encoder test passed");
    end else begin
      $display("dns_name_label_encoder test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("dns_name_label_encoder test failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/dnsle_pkg.sv
hw/rtl/dnsle_datapath.sv
hw/rtl/dnsle_ctrl.sv
hw/rtl/dns_name_label_encoder.sv
tb/sv/testbench.sv
